### design/qro_pkg.sv
// ----------------------------------------------------------------------------
// qro_pkg
// Shared types and constants for the quad/rectangle overlap pipeline.
// ----------------------------------------------------------------------------
package qro_pkg;

    // Register stages from input transfer to output register
    localparam int NUM_STAGES  = 5;
    localparam int NUM_CORNERS = 4;

    // Orientation sign, canonical: never both bits set
    typedef struct packed {
        logic pos;
        logic neg;
    } t_sgn;

    // Rectangle size flags carried down the pipe
    typedef struct packed {
        logic w_nz;
        logic h_nz;
    } t_dim_flags;

    // Results of the rectangle-side tests
    // edge_orient[j][i]: orientation of quad corner i against rectangle edge j
    typedef struct packed {
        logic [NUM_CORNERS-1:0]                    corner_in;
        t_sgn [NUM_CORNERS-1:0][NUM_CORNERS-1:0]   edge_orient;
    } t_rect_flags;

    function automatic t_sgn f_sgn(input logic is_pos, input logic is_neg);
        t_sgn s;
        s.pos = is_pos;
        s.neg = is_neg;
        return s;
    endfunction

endpackage

### design/qro_front.sv
// ----------------------------------------------------------------------------
// qro_front
// Capture stage and difference stage: far rectangle edges, quad edge vectors
// and corner-to-rectangle offsets.
// ----------------------------------------------------------------------------
module qro_front #(
    parameter int COORD_BITS = 20
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_qx [4],
    input  logic signed [COORD_BITS-1:0] i_qy [4],
    input  logic signed [COORD_BITS-1:0] i_rx,
    input  logic signed [COORD_BITS-1:0] i_ry,
    input  logic        [COORD_BITS-3:0] i_rw,
    input  logic        [COORD_BITS-3:0] i_rh,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [COORD_BITS:0]   o_ex [4],
    output logic signed [COORD_BITS:0]   o_ey [4],
    output logic signed [COORD_BITS+1:0] o_dx [4][2],
    output logic signed [COORD_BITS+1:0] o_dy [4][2],
    output qro_pkg::t_dim_flags          o_dims
);

    localparam int CW = COORD_BITS;
    localparam int EW = COORD_BITS + 1;
    localparam int DW = COORD_BITS + 2;

    logic                  r_v1, r_v2;
    logic                  load1, load2;
    logic signed [CW-1:0]  r_qx [4];
    logic signed [CW-1:0]  r_qy [4];
    logic signed [CW-1:0]  r_rx, r_ry;
    logic signed [EW-1:0]  r_rr, r_rb;
    qro_pkg::t_dim_flags   r_dims1, r_dims2;
    logic signed [EW-1:0]  r_ex [4];
    logic signed [EW-1:0]  r_ey [4];
    logic signed [DW-1:0]  r_dx [4][2];
    logic signed [DW-1:0]  r_dy [4][2];

    assign load2   = !r_v2 || i_ready;
    assign load1   = !r_v1 || load2;
    assign o_ready = load1;

    // Stage 1: capture, form right and bottom edges at full width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (load1) begin
            r_v1 <= i_valid;
        end
        if (load1) begin
            for (int i = 0; i < 4; i++) begin
                r_qx[i] <= i_qx[i];
                r_qy[i] <= i_qy[i];
            end
            r_rx         <= i_rx;
            r_ry         <= i_ry;
            r_rr         <= EW'(i_rx) + EW'(i_rw);
            r_rb         <= EW'(i_ry) + EW'(i_rh);
            r_dims1.w_nz <= |i_rw;
            r_dims1.h_nz <= |i_rh;
        end
    end

    // Stage 2: edge vectors and offsets to the two x and two y rectangle lines
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (load2) begin
            r_v2 <= r_v1;
        end
        if (load2) begin
            for (int i = 0; i < 4; i++) begin
                r_ex[i]    <= EW'(r_qx[(i + 1) % 4]) - EW'(r_qx[i]);
                r_ey[i]    <= EW'(r_qy[(i + 1) % 4]) - EW'(r_qy[i]);
                r_dx[i][0] <= DW'(r_rx) - DW'(r_qx[i]);
                r_dx[i][1] <= DW'(r_rr) - DW'(r_qx[i]);
                r_dy[i][0] <= DW'(r_ry) - DW'(r_qy[i]);
                r_dy[i][1] <= DW'(r_rb) - DW'(r_qy[i]);
            end
            r_dims2 <= r_dims1;
        end
    end

    assign o_valid = r_v2;
    assign o_ex    = r_ex;
    assign o_ey    = r_ey;
    assign o_dx    = r_dx;
    assign o_dy    = r_dy;
    assign o_dims  = r_dims2;

endmodule

### design/qro_mul.sv
// ----------------------------------------------------------------------------
// qro_mul
// Product stage: partial cross products of each quad edge against the
// rectangle lines, plus the rectangle-side corner and orientation tests.
// ----------------------------------------------------------------------------
module qro_mul #(
    parameter int COORD_BITS = 20
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [COORD_BITS:0]     i_ex [4],
    input  logic signed [COORD_BITS:0]     i_ey [4],
    input  logic signed [COORD_BITS+1:0]   i_dx [4][2],
    input  logic signed [COORD_BITS+1:0]   i_dy [4][2],
    input  qro_pkg::t_dim_flags            i_dims,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [2*COORD_BITS+2:0] o_py [4][2],
    output logic signed [2*COORD_BITS+2:0] o_px [4][2],
    output qro_pkg::t_rect_flags           o_flags
);

    localparam int PW = 2 * COORD_BITS + 3;

    logic                  r_v;
    logic                  load;
    logic signed [PW-1:0]  r_py [4][2];
    logic signed [PW-1:0]  r_px [4][2];
    qro_pkg::t_rect_flags  r_flags;
    qro_pkg::t_rect_flags  n_flags;

    assign load    = !r_v || i_ready;
    assign o_ready = load;

    // Rectangle edges are axis aligned, so their orientations reduce to
    // signs of the offsets, gated by a non-zero side length
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_flags.corner_in[i] = (i_dx[i][0] <= 0) && (i_dx[i][1] >= 0) &&
                                   (i_dy[i][0] <= 0) && (i_dy[i][1] >= 0);
            // top edge, left to right
            n_flags.edge_orient[0][i] = qro_pkg::f_sgn(
                i_dims.w_nz && (i_dy[i][0] < 0), i_dims.w_nz && (i_dy[i][0] > 0));
            // right edge, downwards
            n_flags.edge_orient[1][i] = qro_pkg::f_sgn(
                i_dims.h_nz && (i_dx[i][1] > 0), i_dims.h_nz && (i_dx[i][1] < 0));
            // bottom edge, right to left
            n_flags.edge_orient[2][i] = qro_pkg::f_sgn(
                i_dims.w_nz && (i_dy[i][1] > 0), i_dims.w_nz && (i_dy[i][1] < 0));
            // left edge, upwards
            n_flags.edge_orient[3][i] = qro_pkg::f_sgn(
                i_dims.h_nz && (i_dx[i][0] < 0), i_dims.h_nz && (i_dx[i][0] > 0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (load) begin
            r_v <= i_valid;
        end
        if (load) begin
            for (int i = 0; i < 4; i++) begin
                for (int k = 0; k < 2; k++) begin
                    r_py[i][k] <= PW'(i_ex[i]) * PW'(i_dy[i][k]);
                    r_px[i][k] <= PW'(i_ey[i]) * PW'(i_dx[i][k]);
                end
            end
            r_flags <= n_flags;
        end
    end

    assign o_valid = r_v;
    assign o_py    = r_py;
    assign o_px    = r_px;
    assign o_flags = r_flags;

endmodule

### design/qro_cross.sv
// ----------------------------------------------------------------------------
// qro_cross
// Cross product stage: subtract partial products, keep the sign of each
// quad edge against each rectangle corner.
// ----------------------------------------------------------------------------
module qro_cross #(
    parameter int COORD_BITS = 20
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [2*COORD_BITS+2:0]       i_py [4][2],
    input  logic signed [2*COORD_BITS+2:0]       i_px [4][2],
    input  qro_pkg::t_rect_flags                 i_flags,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output qro_pkg::t_sgn [3:0][3:0]             o_quad_orient,
    output qro_pkg::t_rect_flags                 o_flags
);

    localparam int PW = 2 * COORD_BITS + 3;
    localparam int XW = PW + 1;

    logic                      r_v;
    logic                      load;
    logic signed [XW-1:0]      cross_val [4][4];
    qro_pkg::t_sgn [3:0][3:0]  n_orient;
    qro_pkg::t_sgn [3:0][3:0]  r_orient;
    qro_pkg::t_rect_flags      r_flags;

    assign load    = !r_v || i_ready;
    assign o_ready = load;

    // Corner j takes the bottom line for j = 2, 3 and the right line for j = 1, 2
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                cross_val[i][j] = XW'((j >= 2) ? i_py[i][1] : i_py[i][0]) -
                                  XW'((j == 1 || j == 2) ? i_px[i][1] : i_px[i][0]);
                n_orient[i][j] = qro_pkg::f_sgn(
                    !cross_val[i][j][XW-1] && (|cross_val[i][j]),
                    cross_val[i][j][XW-1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (load) begin
            r_v <= i_valid;
        end
        if (load) begin
            r_orient <= n_orient;
            r_flags  <= i_flags;
        end
    end

    assign o_valid       = r_v;
    assign o_quad_orient = r_orient;
    assign o_flags       = r_flags;

endmodule

### design/quad_rectangle_overlap.sv
// ----------------------------------------------------------------------------
// quad_rectangle_overlap
// Overlap test between a convex quadrilateral and an axis-aligned rectangle.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; each item runs through five register stages
// (capture, differences, products, cross signs, combine) and backpressure
// halts only the stages that hold data.
// Reset: synchronous, active low; clears all stage valid bits, so the pipe
// comes out of reset empty and ready. Payload registers are not reset.
// ----------------------------------------------------------------------------
module quad_rectangle_overlap #(
    parameter int COORD_BITS = 20
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // fields from bit 0 up: q0_x, q0_y, q1_x, q1_y, q2_x, q2_y, q3_x, q3_y,
    // rect_x, rect_y (COORD_BITS each), rect_w, rect_h (COORD_BITS-2 each),
    // zero padding to whole bytes
    input  logic [((12*COORD_BITS-4+7)/8)*8-1:0]     i_s_axis_tdata,
    output logic                                     o_m_axis_tvalid,
    input  logic                                     i_m_axis_tready,
    // fields from bit 0 up: overlaps, zero padding
    output logic [7:0]                               o_m_axis_tdata
);

    localparam int CW    = COORD_BITS;
    localparam int SW    = COORD_BITS - 2;
    localparam int PW    = 2 * COORD_BITS + 3;
    localparam int CNT_W = $clog2(qro_pkg::NUM_STAGES + 1);

    // Unpacked input fields
    logic signed [CW-1:0]   in_qx [4];
    logic signed [CW-1:0]   in_qy [4];
    logic signed [CW-1:0]   in_rx, in_ry;
    logic        [SW-1:0]   in_rw, in_rh;

    // Stage links
    logic                   fr_valid, fr_ready;
    logic signed [CW:0]     fr_ex [4];
    logic signed [CW:0]     fr_ey [4];
    logic signed [CW+1:0]   fr_dx [4][2];
    logic signed [CW+1:0]   fr_dy [4][2];
    qro_pkg::t_dim_flags    fr_dims;

    logic                   mu_valid, mu_ready;
    logic signed [PW-1:0]   mu_py [4][2];
    logic signed [PW-1:0]   mu_px [4][2];
    qro_pkg::t_rect_flags   mu_flags;

    logic                      cr_valid, cr_ready;
    qro_pkg::t_sgn [3:0][3:0]  cr_quad_orient;
    qro_pkg::t_rect_flags      cr_flags;

    // Output stage
    logic                   r_out_valid;
    logic                   r_overlaps;
    logic                   n_overlaps;
    logic                   out_load;

    // Items inside the pipe, for checking only
    logic [CNT_W-1:0]       r_inflight;
    logic [CNT_W-1:0]       n_inflight;
    logic                   in_xfer, out_xfer;

    // Unpack the input transfer, first field in the lowest bits
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            in_qx[i] = i_s_axis_tdata[(2*i)*CW +: CW];
            in_qy[i] = i_s_axis_tdata[(2*i+1)*CW +: CW];
        end
        in_rx = i_s_axis_tdata[8*CW +: CW];
        in_ry = i_s_axis_tdata[9*CW +: CW];
        in_rw = i_s_axis_tdata[10*CW +: SW];
        in_rh = i_s_axis_tdata[10*CW+SW +: SW];
    end

    // Stages 1 and 2: capture and differences
    qro_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_qx    (in_qx),
        .i_qy    (in_qy),
        .i_rx    (in_rx),
        .i_ry    (in_ry),
        .i_rw    (in_rw),
        .i_rh    (in_rh),
        .o_valid (fr_valid),
        .i_ready (fr_ready),
        .o_ex    (fr_ex),
        .o_ey    (fr_ey),
        .o_dx    (fr_dx),
        .o_dy    (fr_dy),
        .o_dims  (fr_dims)
    );

    // Stage 3: products and rectangle-side tests
    qro_mul #(
        .COORD_BITS (COORD_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_ex    (fr_ex),
        .i_ey    (fr_ey),
        .i_dx    (fr_dx),
        .i_dy    (fr_dy),
        .i_dims  (fr_dims),
        .o_valid (mu_valid),
        .i_ready (mu_ready),
        .o_py    (mu_py),
        .o_px    (mu_px),
        .o_flags (mu_flags)
    );

    // Stage 4: cross product signs
    qro_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (mu_valid),
        .o_ready       (mu_ready),
        .i_py          (mu_py),
        .i_px          (mu_px),
        .i_flags       (mu_flags),
        .o_valid       (cr_valid),
        .i_ready       (cr_ready),
        .o_quad_orient (cr_quad_orient),
        .o_flags       (cr_flags)
    );

    // Stage 5: combine the three tests.
    // Corner of rectangle inside quad: no corner sees both a positive and a
    // negative edge sign. Quad corner inside rectangle: straight from the
    // flags. Edge crossing: the rectangle edge's end corners lie on different
    // orientations of the quad edge, and the quad edge's end corners on
    // different orientations of the rectangle edge.
    always_comb begin
        logic any_pos;
        logic any_neg;
        n_overlaps = |cr_flags.corner_in;
        for (int j = 0; j < 4; j++) begin
            any_pos = 1'b0;
            any_neg = 1'b0;
            for (int i = 0; i < 4; i++) begin
                any_pos = any_pos | cr_quad_orient[i][j].pos;
                any_neg = any_neg | cr_quad_orient[i][j].neg;
            end
            n_overlaps = n_overlaps | !(any_pos && any_neg);
        end
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                n_overlaps = n_overlaps |
                    ((cr_quad_orient[i][j] != cr_quad_orient[i][(j + 1) % 4]) &&
                     (cr_flags.edge_orient[j][i] != cr_flags.edge_orient[j][(i + 1) % 4]));
            end
        end
    end

    // Hold the result while the sink stalls, advance otherwise
    assign out_load = !r_out_valid || i_m_axis_tready;
    assign cr_ready = out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= cr_valid;
        end
        if (out_load) begin
            r_overlaps <= n_overlaps;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_overlaps};

    // Occupancy count for the checks below
    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_xfer = r_out_valid && i_m_axis_tready;

    always_comb begin
        n_inflight = r_inflight;
        if (in_xfer && !out_xfer) begin
            n_inflight = r_inflight + CNT_W'(1);
        end else if (!in_xfer && out_xfer) begin
            n_inflight = r_inflight - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    // The pipe never holds more items than it has stages
    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= CNT_W'(qro_pkg::NUM_STAGES))
        else $error("pipeline holds more items than stages");

    // A result is only offered for an item that entered
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_inflight != '0))
        else $error("result offered with empty pipeline");

    // Input backpressure only when every stage is full and the sink stalls
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |->
            (o_m_axis_tvalid && !i_m_axis_tready &&
             r_inflight == CNT_W'(qro_pkg::NUM_STAGES)))
        else $error("input stalled while pipeline has room");

    // An empty pipe always takes input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight == '0) |-> o_s_axis_tready)
        else $error("empty pipeline not ready");

endmodule
